>>> design/stbs_pkg.sv
// shared types and codes for the sorted table with binary search
package stbs_pkg;

    // field widths fixed by the interface
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 10;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_LOADED    = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_FOUND     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_SCAN,
        ST_LD_CMP,
        ST_LD_PUT,
        ST_Q_PROBE,
        ST_Q_CMP,
        ST_RESP
    } state_t;

endpackage

>>> design/stbs_ram.sv
// generic simple dual-port ram with one write port and a registered read port
module stbs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sorted_table_binary_search.sv
// Sorted table of up to DEPTH signed 64-bit values with binary search lookup.
// The table is kept in ascending order at all times: a load walks down from
// the top of the table, moving every larger value up by one place, and writes
// the new value into the gap; a load into a full table is refused with
// status full. A query runs the classic binary search (midpoint is the
// floor of (left+right)/2, an exact match stops the search); each probe
// issues a read of the midpoint in ST_Q_PROBE and compares the registered
// read data in ST_Q_CMP, because the table ram has a registered read port.
// One item is in work at a time; req_stall is high while an item is in work,
// and a finished result waits in the output register while the next item is
// taken.
module sorted_table_binary_search #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic                                 req_type,
    input  logic signed [stbs_pkg::VALUE_W-1:0]  value,
    // response channel
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic [stbs_pkg::STATUS_W-1:0]        status,
    output logic [stbs_pkg::INDEX_W-1:0]         match_index
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned MID_W = (CNT_W > stbs_pkg::INDEX_W) ? CNT_W : stbs_pkg::INDEX_W;

    stbs_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic signed [stbs_pkg::VALUE_W-1:0] key_reg, key_next;
    stbs_pkg::status_t res_status_reg, res_status_next;
    logic [stbs_pkg::INDEX_W-1:0] res_index_reg, res_index_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [stbs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [stbs_pkg::INDEX_W-1:0]  match_index_reg, match_index_next;

    // ram ports
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [stbs_pkg::VALUE_W-1:0]  ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [stbs_pkg::VALUE_W-1:0]  ram_rdata;

    // datapath helpers
    logic [CNT_W-1:0]  k_m1, k_m2;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid_calc;
    logic [MID_W-1:0]  mid_ext;
    logic signed [stbs_pkg::VALUE_W-1:0] probe;

    assign k_m1     = k_reg - CNT_W'(1);
    assign k_m2     = k_reg - CNT_W'(2);
    // floor((lo + hi - 1) / 2) with hi_reg holding the exclusive right bound
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid_calc = mid_sum[CNT_W:1];
    assign mid_ext  = MID_W'(mid_reg);
    assign probe    = $signed(ram_rdata);

    // table storage
    stbs_ram #(
        .WIDTH (stbs_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= stbs_pkg::ST_IDLE;
            count_reg       <= '0;
            k_reg           <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            res_status_reg  <= stbs_pkg::STATUS_LOADED;
            res_index_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            k_reg           <= k_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            mid_reg         <= mid_next;
            res_status_reg  <= res_status_next;
            res_index_reg   <= res_index_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        status_reg      <= status_next;
        match_index_reg <= match_index_next;
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        status_next      = status_reg;
        match_index_next = match_index_reg;
        ram_we           = 1'b0;
        ram_waddr        = k_reg[AW-1:0];
        ram_wdata        = key_reg;
        ram_re           = 1'b0;
        ram_raddr        = k_m1[AW-1:0];

        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next       = value;
                    res_index_next = '0;
                    if (req_type == stbs_pkg::REQ_QUERY)
                    begin
                        lo_next         = '0;
                        hi_next         = count_reg;
                        res_status_next = stbs_pkg::STATUS_NOT_FOUND;
                        state_next      = stbs_pkg::ST_Q_PROBE;
                    end
                    else if (count_reg == CNT_W'(DEPTH))
                    begin
                        res_status_next = stbs_pkg::STATUS_FULL;
                        state_next      = stbs_pkg::ST_RESP;
                    end
                    else
                    begin
                        res_status_next = stbs_pkg::STATUS_LOADED;
                        k_next          = count_reg;
                        state_next      = stbs_pkg::ST_LD_SCAN;
                    end
                end
            end

            // start the walk down from the top of the table
            stbs_pkg::ST_LD_SCAN:
            begin
                if (k_reg == '0)
                begin
                    state_next = stbs_pkg::ST_LD_PUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = k_m1[AW-1:0];
                    state_next = stbs_pkg::ST_LD_CMP;
                end
            end

            // move a larger value up one place, or drop the new value into the gap
            stbs_pkg::ST_LD_CMP:
            begin
                ram_we = 1'b1;
                if (probe > key_reg)
                begin
                    ram_wdata = ram_rdata;
                    k_next    = k_m1;
                    if (k_reg == CNT_W'(1))
                    begin
                        state_next = stbs_pkg::ST_LD_PUT;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = k_m2[AW-1:0];
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = stbs_pkg::ST_RESP;
                end
            end

            // new value is the smallest so far
            stbs_pkg::ST_LD_PUT:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = stbs_pkg::ST_RESP;
            end

            // issue the midpoint read while the window is not empty
            stbs_pkg::ST_Q_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid_calc[AW-1:0];
                    mid_next   = mid_calc;
                    state_next = stbs_pkg::ST_Q_CMP;
                end
                else
                begin
                    state_next = stbs_pkg::ST_RESP;
                end
            end

            // narrow the window or stop on an exact match
            stbs_pkg::ST_Q_CMP:
            begin
                if (probe == key_reg)
                begin
                    res_status_next = stbs_pkg::STATUS_FOUND;
                    res_index_next  = mid_ext[stbs_pkg::INDEX_W-1:0];
                    state_next      = stbs_pkg::ST_RESP;
                end
                else if (probe < key_reg)
                begin
                    lo_next    = mid_reg + CNT_W'(1);
                    state_next = stbs_pkg::ST_Q_PROBE;
                end
                else
                begin
                    hi_next    = mid_reg;
                    state_next = stbs_pkg::ST_Q_PROBE;
                end
            end

            // hand the result to the output register once it is free
            stbs_pkg::ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    match_index_next = res_index_reg;
                    state_next       = stbs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign req_stall   = (state_reg != stbs_pkg::ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign match_index = match_index_reg;

endmodule
